[hw/rtl/aging_life_grid_engine_unit_defines.svh]
// Assertion macros used by the checker file of the life grid engine.
// Depends on nothing; include with the bare file name.
`ifndef AGING_LIFE_GRID_ENGINE_UNIT_DEFINES_SVH
`define AGING_LIFE_GRID_ENGINE_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define ALG_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ALG_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

[hw/rtl/alg_pkg.sv]
// Package of the aging life grid engine: sizes, op codes, shared types.
// Depends on nothing.
package alg_pkg;
  localparam int GridCols = 16;
  localparam int GridRows = 16;
  localparam int NumCells = GridCols * GridRows;
  localparam int XW = 4;
  localparam int YW = 4;
  localparam int AW = 8;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OP_PLANT = 2'd0,
    OP_CLEAR = 2'd1,
    OP_STEP  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [XW-1:0] x_coord;
    logic [YW-1:0] y_coord;
  } in_item_t;

  typedef struct packed {
    logic [8:0] living_count;
    logic       below_minimum;
    logic [7:0] cell_age;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // Command handed from the front part to the back part.
  typedef struct packed {
    op_t        op;
    logic       in_grid;
    logic [7:0] addr;
  } cmd_t;

  // Display color of a stored age.
  function automatic logic [23:0] age_color(input logic [7:0] a);
    logic [7:0] g;
    g = 8'd0;
    if (a == 8'd2) begin
      age_color = {8'd200, 8'd220, 8'd255};
    end else if (a == 8'd3) begin
      age_color = {8'd128, 8'd255, 8'd0};
    end else if (a > 8'd3) begin
      if (a < 8'd11) g = 8'((8'd10 - a) << 5);
      age_color = {8'd255, g, 8'd0};
    end else begin
      age_color = 24'd0;
    end
  endfunction
endpackage

[hw/rtl/alg_if.sv]
// Valid/ready channel interface carrying one payload.
// Depends on nothing; the payload type is a parameter.
interface alg_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/aging_life_grid_engine_unit.sv]
// Step (op 2): an aging pass over all cells, then a life pass over all cells.
// Clear sweeps the whole grid. One item is carried out at a time; the
// generation sequencer with its one-port memory reads sets the step time.
// Reset is synchronous, active low; after reset a pass zeroes the grid and
// no item is carried out until it ends. The threshold resets to 7.
module aging_life_grid_engine_unit (
  input  logic clk,
  input  logic rst_n,
  alg_if.sink   in_ch,
  alg_if.source out_ch,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_threshold
);
  logic [8:0] threshold_r;
  logic cmd_valid, cmd_ready;
  alg_pkg::cmd_t cmd_data;

  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= 9'd7;
    end else if (cfg_valid) begin
      threshold_r <= cfg_threshold;
    end
  end

  alg_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
  );

  alg_back u_back (
    .clk(clk), .rst_n(rst_n), .threshold(threshold_r),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

[hw/rtl/alg_front.sv]
// Front part: accepts items, classifies them and queues commands.
// Depends on alg_pkg.
module alg_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  alg_pkg::in_item_t    in_data,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output alg_pkg::cmd_t        cmd_data
);
  alg_pkg::cmd_t q_r [alg_pkg::QDepth];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  alg_pkg::cmd_t c;
  logic push, pop;

  // Classify the incoming item.
  always_comb begin
    c.op      = alg_pkg::op_t'(in_data.op);
    c.in_grid = ({1'b0, in_data.x_coord} < 5'(alg_pkg::GridCols)) &&
                ({1'b0, in_data.y_coord} < 5'(alg_pkg::GridRows));
    c.addr    = {in_data.y_coord, in_data.x_coord};
  end

  assign in_ready  = cnt_r != 2'(alg_pkg::QDepth);
  assign push      = in_valid && in_ready;
  assign cmd_valid = cnt_r != 2'd0;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_data  = q_r[rp_r];
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  // Two-entry command queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
    end
    if (push) q_r[wp_r] <= c;
  end
endmodule

[hw/rtl/alg_back.sv]
// Back part: grid memory, clear sweep, generation sequencer and result register.
// Depends on alg_pkg.
module alg_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [8:0]           threshold,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  alg_pkg::cmd_t        cmd_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output alg_pkg::out_item_t   out_data
);
  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CLEAR, S_AGE, S_LIFE, S_READ, S_OUT
  } state_t;

  // Two banks: pass one ages bank 0 into bank 1, pass two computes life back into bank 0.
  logic [7:0] mem0 [alg_pkg::NumCells];
  logic [7:0] mem1 [alg_pkg::NumCells];

  state_t     state_r;
  logic [8:0] idx_r;
  logic [3:0] sub_r;
  logic [3:0] nn_r;
  logic [8:0] n_r;
  logic [7:0] rd0_r, rd1_r;
  logic [7:0] cur_r;
  logic       rdv_r;
  alg_pkg::out_item_t res_r;
  logic       ovalid_r;
  alg_pkg::cmd_t cmd_r;

  logic [3:0] cx, cy, nx, ny;
  logic [7:0] raddr;
  logic [7:0] aged;
  logic       live;
  logic [7:0] newa;
  logic [8:0] n_nxt;
  logic [23:0] col;

  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_data  = res_r;
  assign cx = idx_r[3:0];
  assign cy = idx_r[7:4];

  // Neighbor address for sub-step 0..8 (sub 4 is the cell itself).
  always_comb begin
    nx = cx;
    ny = cy;
    case (sub_r)
      4'd0, 4'd1, 4'd2: ny = cy - 4'd1;
      4'd6, 4'd7, 4'd8: ny = cy + 4'd1;
      default: ny = cy;
    endcase
    case (sub_r)
      4'd0, 4'd3, 4'd6: nx = cx - 4'd1;
      4'd2, 4'd5, 4'd8: nx = cx + 4'd1;
      default: nx = cx;
    endcase
    raddr = {ny, nx};
  end

  always_comb begin
    aged = rd0_r;
    if (rd0_r == 8'd1) aged = 8'd0;
    else if (rd0_r == 8'd2) aged = 8'd4;
    else if (rd0_r > 8'd2 && rd0_r != 8'd255) aged = rd0_r + 8'd1;
  end

  assign live = (rd1_r == 8'd1) || (rd1_r > 8'd3);

  always_comb begin
    newa = cur_r;
    if (cur_r != 8'd0) begin
      if (nn_r < 4'd2 || nn_r > 4'd3) newa = 8'd1;
    end else if (nn_r == 4'd3) begin
      newa = 8'd3;
    end
    n_nxt = n_r + 9'(newa > 8'd1);
    col = alg_pkg::age_color(rd0_r);
  end

  // Registered memory reads.
  always_ff @(posedge clk) begin
    rd0_r <= mem0[(state_r == S_AGE) ? idx_r[7:0] : cmd_r.addr];
    rd1_r <= mem1[raddr];
  end

  // Sequencer: one clocked block for state, counters and outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      idx_r    <= 9'd0;
      ovalid_r <= 1'b0;
      rdv_r    <= 1'b0;
    end else begin
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      case (state_r)
        S_INIT, S_CLEAR: begin
          mem0[idx_r[7:0]] <= 8'd0;
          if (idx_r == 9'(alg_pkg::NumCells - 1)) begin
            idx_r <= 9'd0;
            if (state_r == S_INIT) begin
              state_r <= S_IDLE;
            end else begin
              res_r    <= '0;
              ovalid_r <= 1'b1;
              state_r  <= S_OUT;
            end
          end else begin
            idx_r <= idx_r + 9'd1;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd_data;
            idx_r <= 9'd0;
            rdv_r <= 1'b0;
            sub_r <= 4'd0;
            nn_r  <= 4'd0;
            n_r   <= 9'd0;
            case (cmd_data.op)
              alg_pkg::OP_PLANT: begin
                if (cmd_data.in_grid) mem0[cmd_data.addr] <= 8'd2;
                res_r    <= '0;
                ovalid_r <= 1'b1;
                state_r  <= S_OUT;
              end
              alg_pkg::OP_CLEAR: state_r <= S_CLEAR;
              alg_pkg::OP_STEP:  state_r <= S_AGE;
              default:           state_r <= S_READ;
            endcase
          end
        end
        S_AGE: begin
          // Read pipeline: address idx, data in the next cycle.
          if (rdv_r) mem1[idx_r[7:0] - 8'd1] <= aged;
          if (idx_r == 9'(alg_pkg::NumCells)) begin
            idx_r   <= 9'd0;
            rdv_r   <= 1'b0;
            state_r <= S_LIFE;
          end else begin
            idx_r <= idx_r + 9'd1;
            rdv_r <= 1'b1;
          end
        end
        S_LIFE: begin
          // Sub-steps 0..8 issue reads; 1..9 consume them; step 10 writes.
          rdv_r <= (sub_r < 4'd9);
          if (rdv_r) begin
            if (sub_r == 4'd5) cur_r <= rd1_r;
            else if (live) nn_r <= nn_r + 4'd1;
          end
          if (sub_r == 4'd10) begin
            mem0[idx_r[7:0]] <= newa;
            n_r   <= n_nxt;
            nn_r  <= 4'd0;
            sub_r <= 4'd0;
            if (idx_r == 9'(alg_pkg::NumCells - 1)) begin
              res_r    <= {n_nxt, n_nxt < threshold, 32'd0};
              ovalid_r <= 1'b1;
              state_r  <= S_OUT;
            end else begin
              idx_r <= idx_r + 9'd1;
            end
          end else begin
            sub_r <= sub_r + 4'd1;
          end
        end
        S_READ: begin
          // Address was cmd_r.addr in the previous cycle.
          if (rdv_r) begin
            res_r    <= cmd_r.in_grid ? {9'd0, 1'b0, rd0_r, col} : '0;
            ovalid_r <= 1'b1;
            state_r  <= S_OUT;
          end
          rdv_r <= 1'b1;
        end
        S_OUT: begin
          if (!ovalid_r || out_ready) begin
            rdv_r   <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[hw/rtl/alg_checker.sv]
// Port-level checker for the life grid engine, bound to the top level.
// Depends on alg_pkg and aging_life_grid_engine_unit_defines.svh.
`include "aging_life_grid_engine_unit_defines.svh"
module alg_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input alg_pkg::out_item_t out_data
);
  logic step_res;

  // A result with a nonzero living count comes from a step.
  assign step_res = out_valid && out_data.living_count != 9'd0;

  `ALG_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ALG_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))
  `ALG_ASSERT_IMP(a_step_no_color, clk, rst_n, step_res, out_data.cell_age == 8'd0)
endmodule

bind aging_life_grid_engine_unit alg_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);
